>>> rtl/wst_pkg.sv
`default_nettype none

package wst_pkg;

    // Counter widths inside the lexer
    localparam int LINE_BITS   = 24;
    localparam int OFFSET_BITS = 24;

    // Width of the position fields of a result beat
    localparam int FIELD_W = 24;

    // Results that one source byte can cause
    localparam int MAX_RES = 2;

    // Result queue geometry
    localparam int Q_DEPTH = 4;
    localparam int PTR_W   = $clog2(Q_DEPTH);
    localparam int CNT_W   = $clog2(Q_DEPTH + 1);

    // Token kinds
    localparam logic [1:0] KIND_WORD = 2'd0;
    localparam logic [1:0] KIND_NUM  = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;
    localparam logic [1:0] KIND_END  = 2'd3;

    // Characters of interest
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_CASE  = 8'h20;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] BOM_0    = 8'hEF;
    localparam logic [7:0] BOM_1    = 8'hBB;
    localparam logic [7:0] BOM_2    = 8'hBF;

    // Byte order mark progress
    localparam logic [1:0] BOM_IDLE = 2'd0;
    localparam logic [1:0] BOM_GOT1 = 2'd1;
    localparam logic [1:0] BOM_GOT2 = 2'd2;
    localparam logic [1:0] BOM_DONE = 2'd3;

    // Comment keyword progress
    localparam logic [1:0] CM_NONE = 2'd0;
    localparam logic [1:0] CM_N    = 2'd1;
    localparam logic [1:0] CM_NG   = 2'd2;
    localparam logic [1:0] CM_NGL  = 2'd3;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       is_final;
    } src_t;

    typedef struct packed {
        logic [1:0]         token_kind;
        logic signed [63:0] number_value;
        logic [FIELD_W-1:0] line_number;
        logic [FIELD_W-1:0] start_offset;
        logic [FIELD_W-1:0] token_length;
    } tok_t;

    // Results of one accepted byte, in order
    typedef struct packed {
        logic [1:0] count;
        tok_t       first;
        tok_t       second;
    } push_t;

endpackage

`default_nettype wire

>>> rtl/wst_lex.sv
`default_nettype none

module wst_lex (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         accept,
    input  wire wst_pkg::src_t src_data,
    output wst_pkg::push_t    push
);
    import wst_pkg::*;

    typedef struct packed {
        logic fdig;
        logic fmin;
        logic sdig;
        logic rest;
    } flags_t;

    localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [OFFSET_BITS-1:0] OFF_ONE  = OFFSET_BITS'(1);
    localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;

    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [OFFSET_BITS-1:0] len_reg, len_next;
    logic [63:0]            acc_reg, acc_next;
    flags_t                 flags_reg, flags_next;
    logic [1:0]             cm_reg, cm_next;
    logic [1:0]             bom_reg, bom_next;
    logic                   token_reg, token_next;
    logic                   comment_reg, comment_next;
    logic                   cr_reg, cr_next;
    logic                   halt_reg, halt_next;

    logic       b_space;
    logic       b_digit;
    logic [7:0] b_low;
    logic [3:0] b_val;
    logic [63:0] acc_x10;
    logic       nl;
    tok_t       tok_a;
    tok_t       tok_b;
    tok_t       tok_end;
    tok_t       res [MAX_RES];
    logic [1:0] res_n;

    // Build a word, number or bad-number beat from a finished token
    function automatic tok_t make_token(
        input flags_t                 f,
        input logic [63:0]            acc,
        input logic [LINE_BITS-1:0]   line,
        input logic [OFFSET_BITS-1:0] st,
        input logic [OFFSET_BITS-1:0] len
    );
        tok_t r;
        logic num;
        num            = f.fdig | (f.fmin & f.sdig);
        r.number_value = '0;
        r.line_number  = FIELD_W'(line);
        r.start_offset = FIELD_W'(st);
        r.token_length = FIELD_W'(len);
        priority if (num && !f.rest)
        begin
            r.token_kind = KIND_BAD;
        end
        else if (num)
        begin
            r.token_kind   = KIND_NUM;
            r.number_value = acc;
        end
        else
        begin
            r.token_kind = KIND_WORD;
        end
        return r;
    endfunction

    // Classify the incoming byte
    assign b_space = (src_data.source_byte == CH_SPACE) ||
                     ((src_data.source_byte >= CH_TAB) && (src_data.source_byte <= CH_CR));
    assign b_digit = (src_data.source_byte >= CH_ZERO) && (src_data.source_byte <= CH_NINE);
    assign b_low   = src_data.source_byte | CH_CASE;
    assign b_val   = 4'(src_data.source_byte - CH_ZERO);
    assign acc_x10 = (acc_reg << 3) + (acc_reg << 1);

    // Advance the lexer by one byte
    always_comb
    begin
        line_next    = line_reg;
        offset_next  = offset_reg;
        start_next   = start_reg;
        len_next     = len_reg;
        acc_next     = acc_reg;
        flags_next   = flags_reg;
        cm_next      = cm_reg;
        bom_next     = bom_reg;
        token_next   = token_reg;
        comment_next = comment_reg;
        cr_next      = cr_reg;
        halt_next    = halt_reg;
        nl           = 1'b0;
        res_n        = 2'd0;
        res[0]       = '0;
        res[1]       = '0;

        tok_a = make_token(flags_reg, acc_reg, line_reg, start_reg, len_reg);

        if (!halt_reg)
        begin
            // Close the open token on whitespace
            if (!comment_reg && token_reg && b_space)
            begin
                token_next = 1'b0;
                if (cm_reg == CM_NGL)
                begin
                    comment_next = 1'b1;
                end
                else
                begin
                    res[0] = tok_a;
                    res_n  = 2'd1;
                    if (tok_a.token_kind == KIND_BAD)
                    begin
                        halt_next = 1'b1;
                    end
                end
            end

            if (!halt_next)
            begin
                // Count line breaks, folding CR LF into one
                if (src_data.source_byte == CH_CR)
                begin
                    if (line_reg != LINE_MAX)
                    begin
                        line_next = line_reg + LINE_ONE;
                    end
                    cr_next = 1'b1;
                    nl      = 1'b1;
                end
                else if (src_data.source_byte == CH_LF)
                begin
                    if (!cr_reg && (line_reg != LINE_MAX))
                    begin
                        line_next = line_reg + LINE_ONE;
                    end
                    cr_next = 1'b0;
                    nl      = 1'b1;
                end
                else
                begin
                    cr_next = 1'b0;
                end
                if (nl)
                begin
                    comment_next = 1'b0;
                end

                // Start or extend a token
                if (!comment_next && !b_space)
                begin
                    if (!token_next)
                    begin
                        token_next = 1'b1;
                        start_next = offset_reg;
                        len_next   = OFF_ONE;
                        flags_next = '{fdig: b_digit,
                                       fmin: (src_data.source_byte == CH_MINUS),
                                       sdig: 1'b0,
                                       rest: 1'b1};
                        acc_next   = b_digit ? 64'(b_val) : '0;
                        cm_next    = (b_low == CH_N) ? CM_N : CM_NONE;
                    end
                    else
                    begin
                        if ((len_reg == OFF_ONE) && b_digit)
                        begin
                            flags_next.sdig = 1'b1;
                        end
                        if (len_reg != OFF_MAX)
                        begin
                            len_next = len_reg + OFF_ONE;
                        end
                        if (!b_digit)
                        begin
                            flags_next.rest = 1'b0;
                        end
                        else if (flags_reg.rest)
                        begin
                            // Negative numbers accumulate downward
                            acc_next = flags_reg.fmin ? acc_x10 - 64'(b_val)
                                                      : acc_x10 + 64'(b_val);
                        end
                        priority if ((cm_reg == CM_N) && (b_low == CH_G))
                        begin
                            cm_next = CM_NG;
                        end
                        else if ((cm_reg == CM_NG) && (b_low == CH_L))
                        begin
                            cm_next = CM_NGL;
                        end
                        else
                        begin
                            cm_next = CM_NONE;
                        end
                    end
                end

                // Track a leading byte order mark; drop it when complete
                unique case (bom_reg)
                    BOM_IDLE:
                    begin
                        bom_next = (src_data.source_byte == BOM_0) ? BOM_GOT1 : BOM_DONE;
                    end
                    BOM_GOT1:
                    begin
                        bom_next = (src_data.source_byte == BOM_1) ? BOM_GOT2 : BOM_DONE;
                    end
                    BOM_GOT2:
                    begin
                        bom_next = BOM_DONE;
                        if (src_data.source_byte == BOM_2)
                        begin
                            token_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        bom_next = BOM_DONE;
                    end
                endcase
            end
        end

        if (offset_reg != OFF_MAX)
        begin
            offset_next = offset_reg + OFF_ONE;
        end

        tok_b = make_token(flags_next, acc_next, line_next, start_next, len_next);

        tok_end.token_kind   = KIND_END;
        tok_end.number_value = '0;
        tok_end.line_number  = FIELD_W'(line_next);
        tok_end.start_offset = FIELD_W'(offset_next);
        tok_end.token_length = '0;

        // Last byte: flush the open token, mark the end, return to reset
        if (src_data.is_final)
        begin
            if (token_next && !halt_next && (cm_next != CM_NGL))
            begin
                res[res_n[0]] = tok_b;
                res_n         = res_n + 2'd1;
            end
            res[res_n[0]] = tok_end;
            res_n         = res_n + 2'd1;

            line_next    = LINE_ONE;
            offset_next  = '0;
            start_next   = '0;
            len_next     = '0;
            acc_next     = '0;
            flags_next   = '0;
            cm_next      = CM_NONE;
            bom_next     = BOM_IDLE;
            token_next   = 1'b0;
            comment_next = 1'b0;
            cr_next      = 1'b0;
            halt_next    = 1'b0;
        end
    end

    assign push.count  = accept ? res_n : 2'd0;
    assign push.first  = res[0];
    assign push.second = res[1];

    // Hold state between accepted beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg    <= LINE_ONE;
            offset_reg  <= '0;
            start_reg   <= '0;
            len_reg     <= '0;
            acc_reg     <= '0;
            flags_reg   <= '0;
            cm_reg      <= CM_NONE;
            bom_reg     <= BOM_IDLE;
            token_reg   <= 1'b0;
            comment_reg <= 1'b0;
            cr_reg      <= 1'b0;
            halt_reg    <= 1'b0;
        end
        else if (accept)
        begin
            line_reg    <= line_next;
            offset_reg  <= offset_next;
            start_reg   <= start_next;
            len_reg     <= len_next;
            acc_reg     <= acc_next;
            flags_reg   <= flags_next;
            cm_reg      <= cm_next;
            bom_reg     <= bom_next;
            token_reg   <= token_next;
            comment_reg <= comment_next;
            cr_reg      <= cr_next;
            halt_reg    <= halt_next;
        end
    end

    // A halted or commented stream never holds an open token
    a_halt_no_token: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |-> !token_reg)
        else $error("open token while halted");

    a_comment_no_token: assert property (@(posedge clk) disable iff (!rst_n)
        comment_reg |-> !token_reg)
        else $error("open token inside comment");

    // Two results only come from the last byte
    a_two_only_final: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd2) |-> src_data.is_final)
        else $error("two results from a non-final byte");

    // The last byte returns the lexer to its reset state
    a_final_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && src_data.is_final) |=>
            (line_reg == LINE_ONE) && (offset_reg == '0) && !halt_reg && !token_reg)
        else $error("state not cleared after last byte");

endmodule

`default_nettype wire

>>> rtl/wst_queue.sv
`default_nettype none

module wst_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire wst_pkg::push_t push,
    output logic               room,
    output logic               tok_valid,
    input  wire logic          tok_ready,
    output wst_pkg::tok_t      tok_data
);
    import wst_pkg::*;

    tok_t             q [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_p1;
    logic             pop;

    assign wr_ptr_p1 = PTR_W'(wr_ptr_reg + PTR_W'(1));
    assign pop       = tok_valid && tok_ready;
    assign tok_valid = (count_reg != '0);
    assign tok_data  = q[rd_ptr_reg];

    // Take a new byte only while a two-result beat still fits
    assign room = (count_reg <= CNT_W'(Q_DEPTH - MAX_RES));

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = PTR_W'(wr_ptr_reg + PTR_W'(push.count));
        rd_ptr_next = pop ? PTR_W'(rd_ptr_reg + PTR_W'(1)) : rd_ptr_reg;
        count_next  = CNT_W'(count_reg + CNT_W'(push.count) - CNT_W'(pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store result beats in order
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            q[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            q[wr_ptr_p1] <= push.second;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(Q_DEPTH))
        else $error("result queue overflow");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> (count_reg <= CNT_W'(Q_DEPTH - MAX_RES)))
        else $error("push without room");

    a_pointer_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointer gap");

endmodule

`default_nettype wire

>>> rtl/whitespace_tokenizer.sv
// Results of an accepted byte are stored in the result queue behind any waiting beats.
// Throughput: one byte per cycle while src_ready, one beat out per cycle on tok_ready.
// A last byte that closes a token gives two beats; src_ready drops while the
// four-entry result queue holds three or more beats.
// Reset (rst_n, asynchronous): lexer state returns to line 1, offset 0; queue empties.
`default_nettype none

module whitespace_tokenizer (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          src_valid,
    output logic               src_ready,
    input  wire wst_pkg::src_t src_data,
    output logic               tok_valid,
    input  wire logic          tok_ready,
    output wst_pkg::tok_t      tok_data
);
    import wst_pkg::*;

    logic  accept;
    push_t push;
    logic  room;

    assign src_ready = room;
    assign accept    = src_valid && src_ready;

    // Byte-at-a-time lexer
    wst_lex u_lex (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .src_data (src_data),
        .push     (push)
    );

    // Result queue between lexer and consumer
    wst_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_data  (tok_data)
    );

endmodule

`default_nettype wire

>>> verif/tb_whitespace_tokenizer.sv
module tb_whitespace_tokenizer;
    timeunit 1ns;
    timeprecision 1ps;

    import wst_pkg::*;

    localparam int N_DIR       = 26;
    localparam int N_RANDOM    = 400;
    localparam int IDLE_PCT    = 35;
    localparam int HOLD_CYCLES = 100;
    localparam int DRAIN_LIMIT = 2000;
    localparam int MAX_PRINTS  = 40;

    localparam logic [LINE_BITS-1:0]   LINE_TOP = '1;
    localparam logic [OFFSET_BITS-1:0] POS_TOP  = '1;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        bit         typed;
        tok_t       want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic src_valid;
    logic src_ready;
    src_t src_data;
    logic tok_valid;
    logic tok_ready;
    tok_t tok_data;

    // Shadow copy of the lexer state
    logic [LINE_BITS-1:0]   line_cnt;
    logic [OFFSET_BITS-1:0] byte_pos;
    logic [OFFSET_BITS-1:0] lex_pos;
    logic [OFFSET_BITS-1:0] lex_len;
    logic [63:0]            num_acc;
    bit                     lead_digit;
    bit                     lead_minus;
    bit                     second_digit;
    bit                     all_digits;
    logic [1:0]             kw_state;
    logic [1:0]             bom_state;
    bit                     in_token;
    bit                     in_comment;
    bit                     after_cr;
    bit                     halted;

    tok_t       byte_toks [MAX_RES];
    int         byte_tok_cnt;
    tok_t       expected_toks [$];
    logic [7:0] src_text [$];
    dir_row_t   dir_rows [N_DIR];
    int         err_cnt = 0;
    int         n_sent;
    bit         idle_en;
    bit         hold_req;

    whitespace_tokenizer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_data  (tok_data)
    );

    always #2 clk = ~clk;

    task automatic report(string msg);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS)
            $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task automatic reset_lexer();
        line_cnt     = LINE_BITS'(1);
        byte_pos     = '0;
        lex_pos      = '0;
        lex_len      = '0;
        num_acc      = '0;
        lead_digit   = 1'b0;
        lead_minus   = 1'b0;
        second_digit = 1'b0;
        all_digits   = 1'b0;
        kw_state     = CM_NONE;
        bom_state    = BOM_IDLE;
        in_token     = 1'b0;
        in_comment   = 1'b0;
        after_cr     = 1'b0;
        halted       = 1'b0;
    endtask

    // Append one byte to the source being built
    task automatic add_byte(logic [7:0] b);
        src_text.insert(src_text.size(), b);
    endtask

    task automatic add_tok(logic [1:0] kind, logic [63:0] val, logic [FIELD_W-1:0] line,
                           logic [FIELD_W-1:0] start, logic [FIELD_W-1:0] len);
        tok_t t;
        t.token_kind   = kind;
        t.number_value = val;
        t.line_number  = line;
        t.start_offset = start;
        t.token_length = len;
        byte_toks[byte_tok_cnt] = t;
        byte_tok_cnt++;
    endtask

    task automatic bump_line();
        if (line_cnt != LINE_TOP)
            line_cnt++;
    endtask

    // Close the open token: drop it into comment mode, or report it
    task automatic close_token();
        bit is_num;
        in_token = 1'b0;
        if (kw_state == CM_NGL)
        begin
            in_comment = 1'b1;
            return;
        end
        is_num = lead_digit || (lead_minus && lex_len >= 2 && second_digit);
        if (is_num && !all_digits)
        begin
            add_tok(KIND_BAD, '0, line_cnt, lex_pos, lex_len);
            halted = 1'b1;
        end
        else if (is_num)
            add_tok(KIND_NUM, lead_minus ? 64'd0 - num_acc : num_acc, line_cnt, lex_pos, lex_len);
        else
            add_tok(KIND_WORD, '0, line_cnt, lex_pos, lex_len);
    endtask

    // Advance the shadow lexer by one source byte; results land in byte_toks
    task automatic lex_byte(src_t s);
        logic [7:0] b;
        logic [7:0] low;
        bit         sp;
        bit         dig;
        b   = s.source_byte;
        low = b | CH_CASE;
        sp  = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
        dig = (b >= CH_ZERO) && (b <= CH_NINE);
        byte_tok_cnt = 0;
        if (!halted)
        begin
            if (!in_comment && in_token && sp)
                close_token();
            if (!halted)
            begin
                // line breaks, with CR LF counted once
                if (b == CH_CR)
                begin
                    bump_line();
                    after_cr   = 1'b1;
                    in_comment = 1'b0;
                end
                else if (b == CH_LF)
                begin
                    if (!after_cr)
                        bump_line();
                    after_cr   = 1'b0;
                    in_comment = 1'b0;
                end
                else
                    after_cr = 1'b0;

                // open or extend a token
                if (!in_comment && !sp)
                begin
                    if (!in_token)
                    begin
                        in_token     = 1'b1;
                        lex_pos      = byte_pos;
                        lex_len      = OFFSET_BITS'(1);
                        all_digits   = 1'b1;
                        lead_digit   = dig;
                        lead_minus   = (b == CH_MINUS);
                        second_digit = 1'b0;
                        num_acc      = dig ? 64'(b - CH_ZERO) : 64'd0;
                        kw_state     = (low == CH_N) ? CM_N : CM_NONE;
                    end
                    else
                    begin
                        if (lex_len == 1 && dig)
                            second_digit = 1'b1;
                        if (lex_len != POS_TOP)
                            lex_len++;
                        if (!dig)
                            all_digits = 1'b0;
                        else if (all_digits)
                            num_acc = num_acc * 64'd10 + 64'(b - CH_ZERO);
                        if (kw_state == CM_N && low == CH_G)
                            kw_state = CM_NG;
                        else if (kw_state == CM_NG && low == CH_L)
                            kw_state = CM_NGL;
                        else
                            kw_state = CM_NONE;
                    end
                end

                // skip a complete leading byte order mark
                if (bom_state == BOM_IDLE)
                    bom_state = (b == BOM_0) ? BOM_GOT1 : BOM_DONE;
                else if (bom_state == BOM_GOT1)
                    bom_state = (b == BOM_1) ? BOM_GOT2 : BOM_DONE;
                else if (bom_state == BOM_GOT2)
                begin
                    bom_state = BOM_DONE;
                    if (b == BOM_2)
                        in_token = 1'b0;
                end
            end
        end

        if (byte_pos != POS_TOP)
            byte_pos++;

        if (s.is_final)
        begin
            if (in_token && !halted)
                close_token();
            add_tok(KIND_END, '0, line_cnt, byte_pos, '0);
            reset_lexer();
        end
    endtask

    // Offer one beat, hold it until taken, then queue what it should produce
    task automatic send_byte(src_t s, bit typed, tok_t want);
        while (idle_en && !hold_req && $urandom_range(99) < IDLE_PCT)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= s;
        do
            @(posedge clk);
        while (src_ready !== 1'b1);
        lex_byte(s);
        if (typed)
            expected_toks.insert(expected_toks.size(), want);
        else
            for (int i = 0; i < byte_tok_cnt; i++)
                expected_toks.insert(expected_toks.size(), byte_toks[i]);
        n_sent++;
    endtask

    task automatic send_text();
        src_t s;
        foreach (src_text[i])
        begin
            s.source_byte = src_text[i];
            s.is_final    = (i == src_text.size() - 1);
            send_byte(s, 1'b0, '0);
        end
    endtask

    function automatic logic [7:0] rand_ink();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR));
        return c;
    endfunction

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_case();
        return $urandom_range(1) ? CH_CASE : 8'h00;
    endfunction

    task automatic put_gap();
        case ($urandom_range(2))
            0: add_byte(CH_SPACE);
            1: add_byte(8'($urandom_range(CH_TAB, CH_CR)));
            default:
            begin
                add_byte(CH_CR);
                add_byte(CH_LF);
            end
        endcase
    endtask

    // Build one source: optional full or partial mark, tokens, separators
    task automatic build_source();
        int n_tok;
        int r;
        int len;
        src_text.delete();
        r = $urandom_range(99);
        if (r < 20)
        begin
            add_byte(BOM_0);
            add_byte(BOM_1);
            add_byte(BOM_2);
        end
        else if (r < 30)
        begin
            add_byte(BOM_0);
            if ($urandom_range(1))
                add_byte(BOM_1);
        end
        n_tok = $urandom_range(1, 8);
        for (int t = 0; t < n_tok; t++)
        begin
            r = $urandom_range(99);
            if (r < 35)
            begin
                // number, sometimes long enough to wrap
                if ($urandom_range(2) == 0)
                    add_byte(CH_MINUS);
                len = ($urandom_range(3) == 0) ? $urandom_range(15, 22) : $urandom_range(1, 4);
                for (int k = 0; k < len; k++)
                    add_byte(rand_digit());
            end
            else if (r < 42)
            begin
                // number broken by a non-digit
                if ($urandom_range(1))
                    add_byte(CH_MINUS);
                add_byte(rand_digit());
                len = $urandom_range(0, 2);
                for (int k = 0; k < len; k++)
                    add_byte(rand_digit());
                do
                    add_byte(rand_ink());
                while (src_text[$] >= CH_ZERO && src_text[$] <= CH_NINE);
                len = $urandom_range(0, 2);
                for (int k = 0; k < len; k++)
                    add_byte(rand_ink());
            end
            else if (r < 55)
            begin
                // comment keyword in mixed case, with a short body
                add_byte(CH_N ^ rand_case());
                add_byte(CH_G ^ rand_case());
                add_byte(CH_L ^ rand_case());
                if ($urandom_range(3) == 0)
                    add_byte(rand_ink());
                add_byte(CH_SPACE);
                len = $urandom_range(0, 3);
                for (int k = 0; k < len; k++)
                    add_byte(rand_ink());
            end
            else if (r < 62)
            begin
                add_byte(CH_MINUS);
                if ($urandom_range(1))
                    add_byte(rand_ink());
            end
            else
            begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                    add_byte(rand_ink());
            end
            put_gap();
        end
        // half of the time, drop the last separator byte
        if ($urandom_range(1))
            void'(src_text.pop_back());
    endtask

    task automatic build_noise();
        int len;
        src_text.delete();
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++)
            add_byte(8'($urandom_range(255)));
    endtask

    // Short tokens back to back, to fill the result queue fast
    task automatic build_dense();
        src_text.delete();
        for (int k = 0; k < 40; k++)
        begin
            add_byte(rand_ink());
            add_byte(CH_SPACE);
        end
    endtask

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin : check_beat
        tok_t want;
        if (rst_n === 1'b1 && tok_valid === 1'b1 && tok_ready === 1'b1)
        begin
            if (expected_toks.size() == 0)
                report($sformatf("beat with nothing expected, kind %0d offset %0d",
                                 tok_data.token_kind, tok_data.start_offset));
            else
            begin
                want = expected_toks.pop_front();
                if (tok_data.token_kind !== want.token_kind)
                    report($sformatf("kind got %0d want %0d",
                                     tok_data.token_kind, want.token_kind));
                if (tok_data.number_value !== want.number_value)
                    report($sformatf("value got %0d want %0d",
                                     tok_data.number_value, want.number_value));
                if (tok_data.line_number !== want.line_number)
                    report($sformatf("line got %0d want %0d",
                                     tok_data.line_number, want.line_number));
                if (tok_data.start_offset !== want.start_offset)
                    report($sformatf("offset got %0d want %0d",
                                     tok_data.start_offset, want.start_offset));
                if (tok_data.token_length !== want.token_length)
                    report($sformatf("length got %0d want %0d",
                                     tok_data.token_length, want.token_length));
            end
        end
    end

    // Drive the result side: random stalls, plus one long hold-off on request
    initial
    begin
        tok_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                tok_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                tok_ready <= !(idle_en && $urandom_range(99) < IDLE_PCT);
        end
    end

    initial
    begin
        #1_000_000;
        $display("[whitespace_tokenizer] ERROR");
        $finish;
    end

    initial
    begin
        src_t s;
        bit   hold_done;
        rst_n     = 1'b0;
        src_valid = 1'b0;
        src_data  = '0;
        idle_en   = 1'b1;
        hold_req  = 1'b0;
        hold_done = 1'b0;
        n_sent    = 0;
        reset_lexer();

        // Directed bytes; typed expectations where they are obvious
        dir_rows = '{
            '{BOM_0,    1'b0, 1'b0, '0},
            '{BOM_1,    1'b0, 1'b0, '0},
            '{BOM_2,    1'b0, 1'b0, '0},
            '{CH_MINUS, 1'b0, 1'b0, '0},
            '{8'h39,    1'b0, 1'b0, '0},
            '{CH_SPACE, 1'b0, 1'b1, {KIND_NUM, -64'sd9, 24'd1, 24'd3, 24'd2}},
            '{8'h4E,    1'b0, 1'b0, '0},
            '{8'h67,    1'b0, 1'b0, '0},
            '{8'h4C,    1'b0, 1'b0, '0},
            '{CH_SPACE, 1'b0, 1'b0, '0},
            '{8'h78,    1'b0, 1'b0, '0},
            '{CH_CR,    1'b0, 1'b0, '0},
            '{CH_LF,    1'b0, 1'b0, '0},
            '{CH_MINUS, 1'b0, 1'b0, '0},
            '{8'h61,    1'b0, 1'b0, '0},
            '{CH_CR,    1'b0, 1'b1, {KIND_WORD, 64'sd0, 24'd2, 24'd13, 24'd2}},
            '{8'h34,    1'b0, 1'b0, '0},
            '{8'h78,    1'b0, 1'b0, '0},
            '{CH_TAB,   1'b0, 1'b1, {KIND_BAD, 64'sd0, 24'd3, 24'd16, 24'd2}},
            '{8'h7A,    1'b1, 1'b1, {KIND_END, 64'sd0, 24'd3, 24'd20, 24'd0}},
            '{8'hFF,    1'b0, 1'b0, '0},
            '{8'h00,    1'b1, 1'b0, '0},
            '{BOM_0,    1'b0, 1'b0, '0},
            '{8'h41,    1'b1, 1'b0, '0},
            '{CH_MINUS, 1'b1, 1'b0, '0},
            '{8'h0B,    1'b1, 1'b1, {KIND_END, 64'sd0, 24'd1, 24'd1, 24'd0}}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            s.source_byte = dir_rows[i].ch;
            s.is_final    = dir_rows[i].last;
            send_byte(s, dir_rows[i].typed, dir_rows[i].want);
        end

        // Random sources; a quiet stretch in the middle, one long hold-off later
        while (n_sent < N_DIR + N_RANDOM)
        begin
            idle_en = !(n_sent > N_DIR + 150 && n_sent < N_DIR + 300);
            if (!hold_done && n_sent >= N_DIR + 330)
            begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
                build_dense();
            end
            else if ($urandom_range(99) < 15)
                build_noise();
            else
                build_source();
            send_text();
        end
        src_valid <= 1'b0;

        // Drain, then keep watching for stray beats
        for (int w = 0; w < DRAIN_LIMIT && expected_toks.size() != 0; w++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (expected_toks.size() != 0)
            report($sformatf("%0d results never arrived", expected_toks.size()));

        if (err_cnt == 0)
            $display("[whitespace_tokenizer] OK");
        else
            $display("[whitespace_tokenizer] ERROR");
        $finish;
    end

endmodule
